// ===== design/variable_partition_allocator_unit_assert.svh =====
// assertion macros shared by the allocator modules
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
// implication checked on every edge outside reset
`define VPA_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define VPA_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== design/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types and codes of the variable partition allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vpa_pkg;
  // width of addresses and sizes kept in the segment table
  localparam int ADDR_BITS = 16;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_OWNER = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic CFG_TOTAL  = 1'b0;
  localparam logic CFG_POLICY = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  owner_id;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] grant_start;
    logic [15:0] used_memory;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear;      // rebuild table
    logic latch;      // capture request
    logic scan_init;  // reset scan pointer
    logic scan_step;  // evaluate entry at read data, advance
    logic read_pick;  // issue read of chosen entry
    logic commit;     // write chosen entry, maybe start shift
    logic shift_step; // move one entry up
    logic insert;     // write remainder entry
    logic release_e;  // mark found entry free
    logic respond;    // emit result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic split;
    logic full;
    logic shift_done;
  } sts_t;
endpackage

// ===== design/vpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpa_ctrl
// request sequencer of the allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    kind,
  input  vpa_pkg::sts_t sts,
  output logic          busy,
  output vpa_pkg::ctl_t ctl
);
  import vpa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SINIT = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_PICK  = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [1:0] kind_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind_r <= REQ_ALLOC;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) kind_r <= kind;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          if (kind == REQ_ALLOC || kind == REQ_FREE) state_next = S_SINIT;
          else begin
            if (kind == REQ_CLEAR) ctl.clear = 1'b1;
            state_next = S_RESP;
          end
        end
      end
      S_SINIT: begin
        ctl.scan_init = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_PICK;
        else ctl.scan_step = 1'b1;
      end
      S_PICK: begin
        if (!sts.found) state_next = S_RESP;
        else if (kind_r == REQ_FREE) begin
          ctl.release_e = 1'b1;
          state_next = S_RESP;
        end else begin
          ctl.read_pick = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.split && sts.full) state_next = S_RESP;
        else begin
          ctl.commit = 1'b1;
          state_next = sts.split ? S_SHIFT : S_RESP;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          ctl.insert = 1'b1;
          state_next = S_RESP;
        end else ctl.shift_step = 1'b1;
      end
      S_RESP: begin
        ctl.respond = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `include "variable_partition_allocator_unit_assert.svh"
  `VPA_ASSERT_NXT(a_resp_idle, state == S_RESP, state == S_IDLE, "resp not followed by idle")
  `VPA_ASSERT_IMP(a_one_write, 1'b1, $countones({ctl.commit, ctl.shift_step, ctl.insert,
    ctl.release_e, ctl.clear}) <= 1, "several table writes at once")
  `VPA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request left idle")
endmodule

// ===== design/vpa_datapath.sv =====
// ----------------------------------------------------------------------------
// vpa_datapath
// segment table memories, scan and shift logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vpa_datapath #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  vpa_pkg::ctl_t ctl,
  input  vpa_pkg::req_t req,
  input  logic [15:0]   total_memory,
  input  logic [1:0]    fit_policy,
  output vpa_pkg::sts_t sts,
  output vpa_pkg::rsp_t rsp
);
  import vpa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic                 free;
    logic [9:0]           owner;
  } ent_t;

  // entry 0 is held in registers so that clear only rewrites it, the segment count and the used total
  ent_t mem [MAX_SEGMENTS];
  ent_t rd_data;
  ent_t e0;

  logic [CW-1:0] seg_count;
  logic [ADDR_BITS-1:0] used_total;
  req_t r;
  logic [ADDR_BITS-1:0] need;
  logic [CW-1:0] ptr;        // scan / shift pointer
  logic          rd_valid;
  logic [IW-1:0] rd_idx;
  logic          found;
  logic          scanned;    // request went through a table scan
  logic          committed;  // chosen entry was written
  logic [IW-1:0] pick;
  logic [ADDR_BITS-1:0] pick_size;
  ent_t pick_e;
  logic [1:0]    status;
  logic [ADDR_BITS-1:0] grant;
  logic [ADDR_BITS-1:0] rest;

  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ent_t          wr_data;
  ent_t          cur;
  logic          cand;
  logic          better;

  assign need = r.request_size[ADDR_BITS-1:0];
  assign cur  = (rd_idx == '0) ? e0 : rd_data;
  assign rest = pick_e.size - need;

  always_comb begin
    cand = 1'b0;
    if (r.req_type == REQ_FREE) cand = !cur.free && cur.owner == r.owner_id;
    else cand = cur.free && cur.size >= need;
    better = 1'b0;
    if (!found) better = cand;
    else if (r.req_type == REQ_ALLOC && fit_policy == POL_BEST) better = cand && cur.size < pick_size;
    else if (r.req_type == REQ_ALLOC && fit_policy == POL_WORST) better = cand && cur.size > pick_size;
  end

  always_comb begin
    rd_addr = ptr[IW-1:0];
    if (ctl.read_pick) rd_addr = pick;
    else if (ctl.shift_step) rd_addr = IW'(ptr - CW'(1));
    wr_en = 1'b0;
    wr_addr = pick;
    wr_data = pick_e;
    if (ctl.commit) begin
      wr_en = 1'b1;
      wr_data.size = need;
      wr_data.free = 1'b0;
      wr_data.owner = r.owner_id;
    end else if (ctl.release_e) begin
      // found entry was captured in pick_e
      wr_en = 1'b1;
      wr_data.free = 1'b1;
      wr_data.owner = '0;
    end else if (ctl.insert) begin
      wr_en = 1'b1;
      wr_addr = IW'(pick + IW'(1));
      wr_data.start = pick_e.start + need;
      wr_data.size = rest;
      wr_data.free = 1'b1;
      wr_data.owner = '0;
    end else if (ctl.shift_step && rd_valid) begin
      // rd_data holds entry ptr-1 read last cycle, write it at ptr
      wr_en = 1'b1;
      wr_addr = IW'(ptr);
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr != '0) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= CW'(1);
      used_total <= '0;
      e0 <= '{start: '0, size: ADDR_BITS'(16'hFFFF), free: 1'b1, owner: '0};
      ptr <= '0;
      rd_valid <= 1'b0;
      rd_idx <= '0;
      found <= 1'b0;
      scanned <= 1'b0;
      committed <= 1'b0;
      grant <= '0;
    end else begin
      if (ctl.latch) begin
        r <= req;
        grant <= '0;
        scanned <= 1'b0;
        committed <= 1'b0;
      end
      if (ctl.clear) begin
        seg_count <= CW'(1);
        used_total <= '0;
        e0 <= '{start: '0, size: total_memory[ADDR_BITS-1:0], free: 1'b1, owner: '0};
      end
      if (wr_en && wr_addr == '0) e0 <= wr_data;
      if (ctl.scan_init) begin
        ptr <= CW'(1);
        rd_idx <= '0;
        rd_valid <= 1'b1;
        found <= 1'b0;
        scanned <= 1'b1;
      end
      if (ctl.scan_step) begin
        if (better) begin
          found <= 1'b1;
          pick <= rd_idx;
          pick_size <= cur.size;
          pick_e <= cur;
        end
        rd_idx <= ptr[IW-1:0];
        rd_valid <= (ptr < seg_count);
        ptr <= ptr + CW'(1);
      end
      if (ctl.release_e) used_total <= used_total - pick_e.size;
      if (ctl.read_pick) ptr <= seg_count;
      if (ctl.commit) begin
        used_total <= used_total + need;
        grant <= pick_e.start;
        committed <= 1'b1;
        if (rest != '0) seg_count <= seg_count + CW'(1);
        rd_valid <= 1'b0;
      end
      if (ctl.shift_step) begin
        if (rd_valid) ptr <= ptr - CW'(1);
        rd_valid <= !rd_valid;
      end
    end
  end

  always_comb begin
    sts.scan_done  = !rd_valid || (found && r.req_type != REQ_ALLOC)
                     || (found && fit_policy != POL_BEST && fit_policy != POL_WORST);
    sts.found      = found;
    sts.split      = rest != '0;
    sts.full       = seg_count >= CW'(MAX_SEGMENTS);
    sts.shift_done = !rd_valid && (ptr <= CW'({1'b0, pick}) + CW'(1));
  end

  // an allocate that found a segment but wrote nothing hit the full table
  always_comb begin
    status = ST_OK;
    if (scanned && !found) status = (r.req_type == REQ_FREE) ? ST_NO_OWNER : ST_NO_FIT;
    else if (scanned && r.req_type == REQ_ALLOC && !committed) status = ST_FULL;
    rsp.status = status;
    rsp.grant_start = (status != ST_OK) ? 16'd0 : 16'(grant);
    rsp.used_memory = 16'(used_total);
  end

  `include "variable_partition_allocator_unit_assert.svh"
  `VPA_ASSERT_IMP(a_count, 1'b1, seg_count >= CW'(1) && seg_count <= CW'(MAX_SEGMENTS),
    "segment count out of range")
  `VPA_ASSERT_IMP(a_full_nocommit, ctl.commit, !(sts.split && sts.full), "split on full table")
  `VPA_ASSERT_NXT(a_clear_used, ctl.clear, used_total == '0, "clear left memory in use")
endmodule

// ===== design/variable_partition_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// first / best / worst fit segment allocator with address-ordered table
// ----------------------------------------------------------------------------
//  channel   handshake           beat
//  request   start, busy         req (type, owner, size)
//  result    done strobe         rsp (status, grant, used)
//  config    cfg_valid/ready     cfg_index, cfg_data
//
//  allocate: scans the table, one table entry read per scan cycle, then picks,
//  decides and, on a split, moves the later entries up one by one before it responds
//  free: scans the table and releases the found entry; clear and unused codes respond directly
//  sync reset restores one free segment of 65535 units
//  results are a one-cycle done strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module variable_partition_allocator_unit #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  vpa_pkg::req_t req,
  output logic          done,
  output vpa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import vpa_pkg::*;

  logic [15:0] total_memory;
  logic [1:0]  fit_policy;
  ctl_t ctl;
  sts_t sts;

  // config registers, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      total_memory <= 16'hFFFF;
      fit_policy <= POL_FIRST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOTAL:  total_memory <= cfg_data;
        CFG_POLICY: fit_policy <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  vpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(req.req_type),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  vpa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .req(req), .total_memory(total_memory),
    .fit_policy(fit_policy), .sts(sts), .rsp(rsp)
  );

  // result strobe comes straight from the respond state
  assign done = ctl.respond;

  `include "variable_partition_allocator_unit_assert.svh"
  `VPA_ASSERT_IMP(a_done_busy, done, busy, "result while idle")
  `VPA_ASSERT_IMP(a_grant_zero, done && rsp.status != ST_OK, rsp.grant_start == 16'd0,
    "grant on failure")
  `VPA_ASSERT_NXT(a_done_once, done, !done, "result repeated")
endmodule

// ===== bench/vpa_checker.sv =====
// ----------------------------------------------------------------------------
// vpa_checker
// predicts allocator results from request and config beats and compares them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vpa_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  vpa_pkg::req_t req,
  input  logic          done,
  input  vpa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  output int            errors,
  output int            pending
);
  import vpa_pkg::*;

  localparam int NSEG = 32;

  logic [15:0] mem_total;
  logic [1:0]  policy;
  logic [15:0] t_start [NSEG];
  logic [15:0] t_size  [NSEG];
  logic        t_free  [NSEG];
  logic [9:0]  t_owner [NSEG];
  int          t_count;
  logic [15:0] used;
  rsp_t        rsp_q[$];

  assign pending = rsp_q.size();

  function automatic void rebuild();
    for (int k = 0; k < NSEG; k++) begin
      t_start[k] = '0; t_size[k] = '0; t_free[k] = 1'b0; t_owner[k] = '0;
    end
    t_size[0] = mem_total;
    t_free[0] = 1'b1;
    t_count = 1;
    used = '0;
  endfunction

  // apply one request to the table model and return its result
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int pick;
    logic [15:0] rest;
    o = '0;
    pick = -1;
    case (r.req_type)
      REQ_ALLOC: begin
        for (int k = 0; k < t_count; k++) begin
          if (!t_free[k] || t_size[k] < r.request_size) continue;
          if (policy == POL_BEST) begin
            if (pick < 0 || t_size[k] < t_size[pick]) pick = k;
          end else if (policy == POL_WORST) begin
            if (pick < 0 || t_size[k] > t_size[pick]) pick = k;
          end else if (pick < 0) begin
            pick = k;
          end
        end
        if (pick < 0) begin
          o.status = ST_NO_FIT;
        end else begin
          rest = t_size[pick] - r.request_size;
          if (rest != 0 && t_count >= NSEG) begin
            o.status = ST_FULL;
          end else begin
            if (rest != 0) begin
              for (int j = t_count; j > pick + 1; j--) begin
                t_start[j] = t_start[j-1]; t_size[j] = t_size[j-1];
                t_free[j] = t_free[j-1];   t_owner[j] = t_owner[j-1];
              end
              t_start[pick+1] = t_start[pick] + r.request_size;
              t_size[pick+1] = rest;
              t_free[pick+1] = 1'b1;
              t_owner[pick+1] = '0;
              t_count++;
            end
            t_size[pick] = r.request_size;
            t_free[pick] = 1'b0;
            t_owner[pick] = r.owner_id;
            used = used + r.request_size;
            o.status = ST_OK;
            o.grant_start = t_start[pick];
          end
        end
      end
      REQ_FREE: begin
        o.status = ST_NO_OWNER;
        for (int k = 0; k < t_count; k++) begin
          if (!t_free[k] && t_owner[k] == r.owner_id) begin
            t_free[k] = 1'b1;
            t_owner[k] = '0;
            used = used - t_size[k];
            o.status = ST_OK;
            break;
          end
        end
      end
      REQ_CLEAR: rebuild();
      default: ;
    endcase
    o.used_memory = used;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      policy = POL_FIRST;
      mem_total = 16'hFFFF;
      rebuild();
      rsp_q.delete();
      errors <= 0;
    end else begin
      if (done) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, rsp);
          errors <= errors + 1;
        end else begin
          want = rsp_q.pop_front();
          if (rsp.status !== want.status || rsp.grant_start !== want.grant_start
              || rsp.used_memory !== want.used_memory) begin
            $display("%0t: mismatch expected st=%0d grant=%h used=%h",
                     $time, want.status, want.grant_start, want.used_memory);
            $display("%0t:          actual   st=%0d grant=%h used=%h",
                     $time, rsp.status, rsp.grant_start, rsp.used_memory);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) rsp_q.push_back(apply_request(req));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOTAL) mem_total = cfg_data;
        else policy = cfg_data[1:0];
      end
    end
  end
endmodule

// ===== bench/tb_variable_partition_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_variable_partition_allocator_unit
// drives directed and random allocate / free / clear requests under several
// memory sizes and fit policies; a checker beside the block does the scoring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_variable_partition_allocator_unit;
  import vpa_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles;
  bit          calm;     // no idling in the last part of the run

  variable_partition_allocator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vpa_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
    .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog: fails the run if the ~600 items do not finish in time
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random idle gap before some beats, none once calm is set
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // one request beat; start stays high so the next beat can follow directly,
  // the block goes busy after each accept
  task automatic send(input logic [1:0] kind, input logic [9:0] owner,
                      input logic [15:0] size);
    maybe_idle();
    start <= 1'b1;
    req <= '{req_type: kind, owner_id: owner, request_size: size};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wait until the block is idle and all results are in
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // valid stays high so a following write can go back to back
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // new memory size takes effect at the clear that follows, the policy directly
  task automatic setup(input logic [15:0] total, input logic [1:0] pol);
    drain();
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_POLICY, {14'd0, pol});
    cfg_valid <= 1'b0;
    send(REQ_CLEAR, 10'd0, 16'd0);
  endtask

  // mix: mostly allocates and frees among a few owners, plus stray owners, unused codes and clears
  task automatic random_phase(input int n, input logic [15:0] total);
    int pick;
    logic [15:0] sz;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      sz = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, total / 6 + 1));
      if (pick < 55) send(REQ_ALLOC, 10'($urandom_range(0, 7)), sz);
      else if (pick < 88) send(REQ_FREE, 10'($urandom_range(0, 8)), 16'($urandom));
      else if (pick < 93) send(REQ_ALLOC, 10'($urandom), 16'($urandom));
      else if (pick < 96) send(2'd3, 10'($urandom), 16'($urandom));
      else send(REQ_CLEAR, 10'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] tot;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    cycles = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every request code, exact fit, zero size, free misses
    send(REQ_ALLOC, 10'd1023, 16'd1);
    send(REQ_ALLOC, 10'd0, 16'd0);
    send(REQ_ALLOC, 10'd5, 16'hFFFF);
    send(REQ_FREE, 10'd77, 16'd0);
    send(REQ_FREE, 10'd1023, 16'hFFFF);
    send(2'd3, 10'd3, 16'd9);
    send(REQ_CLEAR, 10'd0, 16'd0);
    send(REQ_ALLOC, 10'd2, 16'hFFFF);   // exact fit of whole memory
    send(REQ_ALLOC, 10'd2, 16'd0);
    send(REQ_FREE, 10'd2, 16'd0);
    // fill the table to the segment limit, then hit the full case
    setup(16'd1000, POL_FIRST);
    for (int k = 0; k < 33; k++) send(REQ_ALLOC, 10'(k), 16'd10);
    send(REQ_ALLOC, 10'd40, 16'd1);
    send(REQ_FREE, 10'd3, 16'd0);
    send(REQ_ALLOC, 10'd50, 16'd10);    // exact fit while full
    send(REQ_ALLOC, 10'd51, 16'd5000);  // no fit

    // pause until every result has come
    drain();

    // random phases across memory sizes and all policy codes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: tot = 16'd1;
        1: tot = 16'hFFFF;
        default: tot = 16'($urandom_range(16, 4000));
      endcase
      setup(tot, 2'(ph % 4));
      if (ph == 6) calm = 1'b1;
      random_phase(72, tot);
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/vpa_pkg.sv
design/vpa_ctrl.sv
design/vpa_datapath.sv
design/variable_partition_allocator_unit.sv
bench/vpa_checker.sv
bench/tb_variable_partition_allocator_unit.sv
